### hw/rtl/hsl_to_rgb_converter_macros.svh
`ifndef HSL_TO_RGB_CONVERTER_MACROS_SVH
`define HSL_TO_RGB_CONVERTER_MACROS_SVH

// same-cycle implication
`define HSL_ASSERT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("hsl check failed");

// delayed implication, with the delay given by the dly argument
`define HSL_ASSERT_DELAY(label, clk, rst, ante, dly, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> ##dly (cons)) \
      else $error("hsl delayed check failed");

`endif

### hw/rtl/hsl_pkg.sv
`default_nettype none

package hsl_pkg;

   localparam int HUE_W    = 13;
   localparam int FRAC_W   = 13;
   localparam int BYTE_W   = 8;
   localparam int WGT_W    = 11;
   localparam int LS_W     = 2 * FRAC_W;
   localparam int BASE_W   = 27;
   localparam int Q_W      = 25;
   localparam int P_W      = 27;
   localparam int D_W      = 28;
   localparam int V_W      = D_W + WGT_W + 1;
   localparam int M_W      = V_W - 1 + BYTE_W;
   localparam int PIPE_LAT = 6;

   localparam logic [HUE_W-1:0]  HUE_SIXTH      = 13'd1024;
   localparam logic [HUE_W-1:0]  HUE_HALF       = 13'd3072;
   localparam logic [HUE_W-1:0]  HUE_TWO_THIRDS = 13'd4096;
   localparam logic [FRAC_W-1:0] FRAC_HALF      = 13'd2048;
   localparam logic [WGT_W-1:0]  WGT_FULL       = 11'd1024;

   localparam logic signed [HUE_W+1:0] HUE_THIRD_S = 15'sd2048;
   localparam logic signed [HUE_W+1:0] HUE_TURN_S  = 15'sd6144;

   typedef enum logic [1:0] {
      CHAN_RED,
      CHAN_GREEN,
      CHAN_BLUE
   } chan_type;

   typedef struct packed {
      logic [HUE_W-1:0]  hue;
      logic [FRAC_W-1:0] saturation;
      logic [FRAC_W-1:0] lightness;
   } req_word_type;

   typedef struct packed {
      logic [BYTE_W-1:0] red;
      logic [BYTE_W-1:0] green;
      logic [BYTE_W-1:0] blue;
   } rsp_word_type;

   typedef struct packed {
      logic                        valid;
      logic signed [P_W-1:0]       p;
      logic signed [D_W-1:0]       d;
      logic [2:0][WGT_W-1:0]       wgt;
   } front_type;

   // slope weight of one channel: 0..1024, where 1024 selects q
   function automatic logic [WGT_W-1:0] hue_weight(input logic [HUE_W-1:0] hue,
                                                   input chan_type chan);
      logic signed [HUE_W+1:0] t_raw;
      logic signed [HUE_W+1:0] t_wrap;
      logic [HUE_W-1:0]        t;
      logic [HUE_W-1:0]        t_down;
      logic [WGT_W-1:0]        w;
      t_raw = $signed({2'b00, hue});
      case (chan)
         CHAN_RED:  t_raw = t_raw + HUE_THIRD_S;
         CHAN_BLUE: t_raw = t_raw - HUE_THIRD_S;
         default:   t_raw = t_raw;
      endcase
      if (t_raw < 0) begin
         t_wrap = t_raw + HUE_TURN_S;
      end else if (t_raw > HUE_TURN_S) begin
         t_wrap = t_raw - HUE_TURN_S;
      end else begin
         t_wrap = t_raw;
      end
      t      = t_wrap[HUE_W-1:0];
      t_down = HUE_TWO_THIRDS - t;
      if (t < HUE_SIXTH) begin
         w = t[WGT_W-1:0];
      end else if (t < HUE_HALF) begin
         w = WGT_FULL;
      end else if (t < HUE_TWO_THIRDS) begin
         w = t_down[WGT_W-1:0];
      end else begin
         w = '0;
      end
      return w;
   endfunction

endpackage

`default_nettype wire

### hw/rtl/hsl_to_rgb_converter.sv
`default_nettype none

// a word taken at one edge passes the hsl_front and hsl_chan registers, then shows on rsp_word with rsp_strobe
// throughput: one word per clock cycle, fixed by the six-stage multiply pipeline
// busy is high only while reset is asserted, the receiver cannot stall
// reset clears the pipeline valid bits, words in flight are dropped

module hsl_to_rgb_converter
   import hsl_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         start,
   input  wire req_word_type req_word,
   output logic              busy,
   output logic              rsp_strobe,
   output rsp_word_type      rsp_word
);

   front_type         front;
   logic [2:0]        vld_ff, vld_in;
   logic [BYTE_W-1:0] level [3];
   logic              accept;

   assign busy   = reset;
   assign accept = start & ~busy;

   hsl_front u_front (
      .clock    (clock),
      .reset    (reset),
      .in_valid (accept),
      .in_word  (req_word),
      .front    (front)
   );

   for (genvar i = 0; i < 3; i++) begin : g_chan
      hsl_chan u_chan (
         .clock (clock),
         .p     (front.p),
         .d     (front.d),
         .wgt   (front.wgt[i]),
         .level (level[i])
      );
   end

   assign vld_in = {vld_ff[1:0], front.valid};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   always_comb begin
      rsp_strobe     = vld_ff[2];
      rsp_word.red   = level[CHAN_RED];
      rsp_word.green = level[CHAN_GREEN];
      rsp_word.blue  = level[CHAN_BLUE];
   end

endmodule

`default_nettype wire

### hw/rtl/hsl_front.sv
`default_nettype none

module hsl_front
   import hsl_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         in_valid,
   input  wire req_word_type in_word,
   output front_type         front
);

   logic                  vld1_ff, vld1_in;
   logic                  low1_ff, low1_in;
   logic [LS_W-1:0]       ls1_ff, ls1_in;
   logic [BASE_W-1:0]     base1_ff, base1_in;
   logic [FRAC_W-1:0]     l1_ff;
   logic [2:0][WGT_W-1:0] wgt1_ff, wgt1_in;

   logic                  vld2_ff;
   logic [Q_W-1:0]        q2_ff, q2_in;
   logic [FRAC_W-1:0]     l2_ff;
   logic [2:0][WGT_W-1:0] wgt2_ff;

   logic [BASE_W-1:0]     q_sum;
   front_type             front_ff, front_in;

   // stage 1: l*s product, base term, channel weights
   always_comb begin
      vld1_in = in_valid;
      low1_in = (in_word.lightness < FRAC_HALF);
      ls1_in  = {{FRAC_W{1'b0}}, in_word.lightness} * {{FRAC_W{1'b0}}, in_word.saturation};
      if (low1_in) begin
         base1_in = {2'b00, in_word.lightness, 12'b0};
      end else begin
         base1_in = {1'b0, {1'b0, in_word.lightness} + {1'b0, in_word.saturation}, 12'b0};
      end
      for (int i = 0; i < 3; i++) begin
         wgt1_in[i] = hue_weight(in_word.hue, chan_type'(2'(i)));
      end
   end

   // stage 2: q
   always_comb begin
      if (low1_ff) begin
         q_sum = base1_ff + {1'b0, ls1_ff};
      end else begin
         q_sum = base1_ff - {1'b0, ls1_ff};
      end
      q2_in = q_sum[Q_W-1:0];
   end

   // stage 3: p and q - p
   always_comb begin
      front_in.valid = vld2_ff;
      front_in.p     = $signed({1'b0, l2_ff, 13'b0}) - $signed({2'b00, q2_ff});
      front_in.d     = $signed({2'b00, q2_ff, 1'b0}) - $signed({2'b00, l2_ff, 13'b0});
      front_in.wgt   = wgt2_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld1_ff  <= 1'b0;
         vld2_ff  <= 1'b0;
         front_ff <= '0;
      end else begin
         vld1_ff  <= vld1_in;
         vld2_ff  <= vld1_ff;
         front_ff <= front_in;
      end
   end

   always_ff @(posedge clock) begin
      low1_ff      <= low1_in;
      ls1_ff       <= ls1_in;
      base1_ff     <= base1_in;
      l1_ff        <= in_word.lightness;
      wgt1_ff      <= wgt1_in;
      q2_ff        <= q2_in;
      l2_ff        <= l1_ff;
      wgt2_ff      <= wgt1_ff;
   end

   assign front = front_ff;

endmodule

`default_nettype wire

### hw/rtl/hsl_chan.sv
`default_nettype none

module hsl_chan
   import hsl_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic signed [P_W-1:0] p,
   input  wire logic signed [D_W-1:0] d,
   input  wire logic [WGT_W-1:0]      wgt,
   output logic [BYTE_W-1:0]          level
);

   logic signed [V_W-1:0] prod_ff, prod_in;
   logic signed [P_W-1:0] p_ff;
   logic signed [V_W-1:0] v_ff, v_in;
   logic [BYTE_W-1:0]     level_ff, level_in;
   logic [M_W-1:0]        scaled;
   logic [M_W-35:0]       top_bits;

   // value scaled by 2^34 is p*1024 + (q-p)*weight
   assign prod_in = d * $signed({1'b0, wgt});
   assign v_in    = prod_ff + $signed({{(V_W-P_W-10){p_ff[P_W-1]}}, p_ff, 10'b0});

   // times 255, drop 34 fraction bits, clamp
   always_comb begin
      scaled   = {v_ff[V_W-2:0], {BYTE_W{1'b0}}} - {{BYTE_W{1'b0}}, v_ff[V_W-2:0]};
      top_bits = scaled[M_W-1:34];
      if (v_ff <= 0) begin
         level_in = '0;
      end else if (top_bits > (M_W-34)'(255)) begin
         level_in = '1;
      end else begin
         level_in = top_bits[BYTE_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      prod_ff  <= prod_in;
      p_ff     <= p;
      v_ff     <= v_in;
      level_ff <= level_in;
   end

   assign level = level_ff;

endmodule

`default_nettype wire

### hw/rtl/hsl_checker.sv
`default_nettype none

`include "hsl_to_rgb_converter_macros.svh"

module hsl_checker
   import hsl_pkg::*;
(
   input wire logic         clock,
   input wire logic         reset,
   input wire logic         start,
   input wire logic         busy,
   input wire req_word_type req_word,
   input wire logic         rsp_strobe,
   input wire rsp_word_type rsp_word
);

   logic accept;
   logic gray_word;
   logic black_word;
   logic rgb_equal;

   assign accept     = start && !busy;
   assign gray_word  = accept && (req_word.saturation == '0);
   assign black_word = accept && (req_word.lightness == '0);
   assign rgb_equal  = (rsp_word.red == rsp_word.green) && (rsp_word.green == rsp_word.blue);

   `HSL_ASSERT_DELAY(a_word_out, clock, reset, accept, PIPE_LAT, rsp_strobe)
   `HSL_ASSERT(a_no_spurious, clock, reset, rsp_strobe, $past(accept, PIPE_LAT))
   `HSL_ASSERT_DELAY(a_gray, clock, reset, gray_word, PIPE_LAT, rgb_equal)
   `HSL_ASSERT_DELAY(a_black, clock, reset, black_word, PIPE_LAT, rsp_word == '0)

endmodule

bind hsl_to_rgb_converter hsl_checker u_hsl_checker (
   .clock      (clock),
   .reset      (reset),
   .start      (start),
   .busy       (busy),
   .req_word   (req_word),
   .rsp_strobe (rsp_strobe),
   .rsp_word   (rsp_word)
);

`default_nettype wire

### sim/tb_top.sv
`default_nettype none

module tb_top;
   import hsl_pkg::*;

   localparam longint TURN       = 6144;
   localparam longint THIRD      = 2048;
   localparam longint SIXTH      = 1024;
   localparam longint HALF_TURN  = 3072;
   localparam longint TWO_THIRDS = 4096;
   localparam longint UNIT       = 4096;
   localparam longint MID        = 2048;
   localparam int     CYCLE_LIMIT = 200000;
   localparam int     MAX_GAP     = 19;
   localparam int     RANDOM_WORDS = 550;
   localparam int     SHOW_LIMIT   = 30;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         start = 1'b0;
   req_word_type req_word = '0;
   logic         busy;
   logic         rsp_strobe;
   rsp_word_type rsp_word;

   rsp_word_type rgb_pending[$];
   int           mismatches = 0;
   int           words_sent = 0;
   int           words_checked = 0;
   int           cycle_count = 0;
   bit           burst = 1'b0;

   hsl_to_rgb_converter uut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .req_word   (req_word),
      .busy       (busy),
      .rsp_strobe (rsp_strobe),
      .rsp_word   (rsp_word)
   );

   always #1 clock = ~clock;

   // channel level scaled by 2^34 from p and q scaled by 2^24
   function automatic longint channel_level(input longint p, input longint q,
                                            input longint t);
      longint th;
      th = t;
      if (th < 0) begin
         th = th + TURN;
      end else if (th > TURN) begin
         th = th - TURN;
      end
      if (th < SIXTH) begin
         return p * SIXTH + (q - p) * th;
      end else if (th < HALF_TURN) begin
         return q * SIXTH;
      end else if (th < TWO_THIRDS) begin
         return p * SIXTH + (q - p) * (TWO_THIRDS - th);
      end
      return p * SIXTH;
   endfunction

   function automatic logic [BYTE_W-1:0] level_to_byte(input longint v);
      longint r;
      if (v <= 0) begin
         return '0;
      end
      r = (v * 255) >>> 34;
      return (r > 255) ? 8'd255 : r[BYTE_W-1:0];
   endfunction

   function automatic rsp_word_type predict_rgb(input req_word_type w);
      longint h;
      longint s;
      longint l;
      longint q;
      longint p;
      rsp_word_type o;
      h = longint'(w.hue);
      s = longint'(w.saturation);
      l = longint'(w.lightness);
      if (l < MID) begin
         q = l * (UNIT + s);
      end else begin
         q = l * UNIT + s * UNIT - l * s;
      end
      p = 2 * l * UNIT - q;
      o.red   = level_to_byte(channel_level(p, q, h + THIRD));
      o.green = level_to_byte(channel_level(p, q, h));
      o.blue  = level_to_byte(channel_level(p, q, h - THIRD));
      return o;
   endfunction

   task automatic report_mismatch(input string what, input int got, input int want);
      mismatches++;
      if (mismatches <= SHOW_LIMIT) begin
         $display("tb_top: mismatch on %s at cycle %0d: got %0d, expected %0d",
                  what, cycle_count, got, want);
      end
   endtask

   task automatic send_pixel(input logic [HUE_W-1:0] hue,
                             input logic [FRAC_W-1:0] sat,
                             input logic [FRAC_W-1:0] light);
      int gap;
      req_word_type w;
      gap = burst ? 0 : $urandom_range(0, MAX_GAP);
      w.hue        = hue;
      w.saturation = sat;
      w.lightness  = light;
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start    <= 1'b1;
      req_word <= w;
      @(posedge clock);
      while (busy) @(posedge clock);
      rgb_pending.push_back(predict_rgb(w));
      words_sent++;
   endtask

   task automatic test_gray;
      send_pixel(13'd0, 13'd0, 13'd0);
      send_pixel(13'd1000, 13'd0, 13'd4096);
      send_pixel(13'd5000, 13'd0, 13'd2048);
      send_pixel(13'd8191, 13'd0, 13'd8191);
   endtask

   task automatic test_hue_breakpoints;
      send_pixel(13'd0, 13'd4096, 13'd2048);
      send_pixel(13'd1023, 13'd4096, 13'd2048);
      send_pixel(13'd1024, 13'd4096, 13'd2048);
      send_pixel(13'd2048, 13'd4096, 13'd2048);
      send_pixel(13'd3071, 13'd4096, 13'd2048);
      send_pixel(13'd3072, 13'd4096, 13'd2048);
      send_pixel(13'd4095, 13'd4096, 13'd2048);
      send_pixel(13'd4096, 13'd4096, 13'd2048);
      send_pixel(13'd6143, 13'd4096, 13'd2048);
      send_pixel(13'd6144, 13'd4096, 13'd2048);
   endtask

   task automatic test_out_of_range;
      send_pixel(13'd8191, 13'd8191, 13'd8191);
      send_pixel(13'd8191, 13'd4096, 13'd2047);
      send_pixel(13'd6145, 13'd2000, 13'd3000);
      send_pixel(13'd0, 13'd8191, 13'd2047);
      send_pixel(13'd2048, 13'd4096, 13'd8191);
      send_pixel(13'd7000, 13'd8191, 13'd0);
      send_pixel(13'd0, 13'd4096, 13'd4096);
   endtask

   task automatic test_random;
      logic [HUE_W-1:0]  hue;
      logic [FRAC_W-1:0] sat;
      logic [FRAC_W-1:0] light;
      for (int i = 0; i < RANDOM_WORDS; i++) begin
         if (i % 40 == 0) begin
            burst = ($urandom_range(0, 2) == 0);
         end
         if ($urandom_range(0, 4) == 0) begin
            hue   = HUE_W'($urandom_range(0, 8191));
            sat   = FRAC_W'($urandom_range(0, 8191));
            light = FRAC_W'($urandom_range(0, 8191));
         end else begin
            hue   = HUE_W'($urandom_range(0, 6144));
            sat   = ($urandom_range(0, 15) == 0) ? 13'd0 : FRAC_W'($urandom_range(0, 4096));
            light = FRAC_W'($urandom_range(0, 4096));
         end
         send_pixel(hue, sat, light);
      end
      burst = 1'b0;
   endtask

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("tb_top: FAIL");
         $finish;
      end
   end

   always @(posedge clock) begin
      rsp_word_type want;
      if (!reset && rsp_strobe) begin
         if (rgb_pending.size() == 0) begin
            report_mismatch("unexpected word", 1, 0);
         end else begin
            want = rgb_pending.pop_front();
            words_checked++;
            if (rsp_word.red !== want.red) begin
               report_mismatch("red", int'(rsp_word.red), int'(want.red));
            end
            if (rsp_word.green !== want.green) begin
               report_mismatch("green", int'(rsp_word.green), int'(want.green));
            end
            if (rsp_word.blue !== want.blue) begin
               report_mismatch("blue", int'(rsp_word.blue), int'(want.blue));
            end
         end
      end
   end

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_gray;
      test_hue_breakpoints;
      test_out_of_range;
      test_random;
      start <= 1'b0;
      while (rgb_pending.size() != 0) @(posedge clock);
      repeat (PIPE_LAT + 4) @(posedge clock);
      $display("tb_top: sent %0d words (gray, hue breakpoints, out-of-range, random)",
               words_sent);
      $display("tb_top: checked %0d rgb words, %0d mismatches", words_checked, mismatches);
      if (mismatches == 0) begin
         $display("tb_top: PASS");
      end else begin
         $display("tb_top: FAIL");
      end
      $finish;
   end

endmodule

`default_nettype wire
